// ===== sv/aaq_pkg.sv =====
package aaq_pkg;

   localparam int CORDIC_STEPS = 30;
   localparam int CW           = 34;
   localparam int SQ_STEPS     = 32;
   localparam int RW           = 32;
   localparam int REMW         = 36;
   localparam int QB           = 16;
   localparam int PW           = 48;
   localparam int DW           = 49;

   localparam logic signed [34:0]   HALF_PI_Q30 = 35'sd1686629713;
   localparam logic signed [34:0]   PI_Q30      = 35'sd3373259426;
   localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic signed [15:0]   Q14_ONE     = 16'sd16384;

   typedef struct packed {
      logic signed [15:0] axis_x;
      logic signed [15:0] axis_y;
      logic signed [15:0] axis_z;
      logic signed [15:0] angle;
   } req_type;

   typedef struct packed {
      logic signed [15:0] quat_w;
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_z;
   } rsp_type;

   typedef struct packed {
      logic             valid;
      logic             zero;
      logic             neg;
      logic [2:0][15:0] axis;
   } side_type;

   typedef struct packed {
      logic               valid;
      logic               zero;
      logic signed [15:0] w;
      logic [2:0]         flip;
   } div_tag_type;

   function automatic logic [31:0] atan_q30(input logic [4:0] idx);
      logic [31:0] t;
      case (idx)
         5'd0:    t = 32'h3243F6A8;
         5'd1:    t = 32'h1DAC6705;
         5'd2:    t = 32'h0FADBAFC;
         5'd3:    t = 32'h07F56EA6;
         5'd4:    t = 32'h03FEAB76;
         5'd5:    t = 32'h01FFD55B;
         5'd6:    t = 32'h00FFFAAA;
         5'd7:    t = 32'h007FFF55;
         5'd8:    t = 32'h003FFFEA;
         5'd9:    t = 32'h001FFFFD;
         5'd10:   t = 32'h000FFFFF;
         5'd11:   t = 32'h0007FFFF;
         5'd12:   t = 32'h0003FFFF;
         5'd13:   t = 32'h0001FFFF;
         5'd14:   t = 32'h0000FFFF;
         5'd15:   t = 32'h00007FFF;
         5'd16:   t = 32'h00003FFF;
         5'd17:   t = 32'h00001FFF;
         5'd18:   t = 32'h00000FFF;
         5'd19:   t = 32'h000007FF;
         5'd20:   t = 32'h000003FF;
         5'd21:   t = 32'h000001FF;
         5'd22:   t = 32'h000000FF;
         5'd23:   t = 32'h0000007F;
         5'd24:   t = 32'h0000003F;
         5'd25:   t = 32'h0000001F;
         5'd26:   t = 32'h0000000F;
         5'd27:   t = 32'h00000008;
         5'd28:   t = 32'h00000004;
         5'd29:   t = 32'h00000002;
         default: t = 32'h00000000;
      endcase
      return t;
   endfunction

endpackage

// ===== sv/aaq_cordic.sv =====
module aaq_cordic
   import aaq_pkg::*;
(
   input  logic                 clock,
   input  logic                 en,
   input  logic signed [CW-1:0] z_i,
   output logic signed [CW-1:0] c_o,
   output logic signed [CW-1:0] s_o
);

   logic signed [CW-1:0] c_ff [CORDIC_STEPS];
   logic signed [CW-1:0] s_ff [CORDIC_STEPS];
   logic signed [CW-1:0] z_ff [CORDIC_STEPS];

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      logic signed [CW-1:0] c_prev, s_prev, z_prev;
      logic signed [CW-1:0] c_in, s_in, z_in;
      logic signed [CW-1:0] angle_step;

      if (i == 0) begin : g_first
         assign c_prev = CORDIC_GAIN;
         assign s_prev = '0;
         assign z_prev = z_i;
      end else begin : g_next
         assign c_prev = c_ff[i-1];
         assign s_prev = s_ff[i-1];
         assign z_prev = z_ff[i-1];
      end

      assign angle_step = $signed({2'b00, atan_q30(5'(i))});

      always_comb begin
         if (!z_prev[CW-1]) begin
            c_in = c_prev - (s_prev >>> i);
            s_in = s_prev + (c_prev >>> i);
            z_in = z_prev - angle_step;
         end else begin
            c_in = c_prev + (s_prev >>> i);
            s_in = s_prev - (c_prev >>> i);
            z_in = z_prev + angle_step;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            c_ff[i] <= c_in;
            s_ff[i] <= s_in;
            z_ff[i] <= z_in;
         end
      end
   end

   assign c_o = c_ff[CORDIC_STEPS-1];
   assign s_o = s_ff[CORDIC_STEPS-1];

endmodule

// ===== sv/aaq_div.sv =====
module aaq_div
   import aaq_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  div_tag_type            tag_i,
   input  logic [2:0][DW-1:0]     num_i,
   input  logic [RW-1:0]          den_i,
   output div_tag_type            tag_o,
   output logic [2:0][QB-1:0]     quo_o
);

   div_tag_type          tag_ff [QB];
   logic [2:0][DW-1:0]   rem_ff [QB];
   logic [2:0][QB-1:0]   quo_ff [QB];
   logic [RW-1:0]        den_ff [QB];

   for (genvar j = 0; j < QB; j++) begin : g_bit
      localparam int K = QB - 1 - j;
      div_tag_type        tag_prev;
      logic [2:0][DW-1:0] rem_prev, rem_in;
      logic [2:0][QB-1:0] quo_prev, quo_in;
      logic [RW-1:0]      den_prev;
      logic [DW-1:0]      den_sh;

      if (j == 0) begin : g_first
         assign tag_prev = tag_i;
         assign rem_prev = num_i;
         assign quo_prev = '0;
         assign den_prev = den_i;
      end else begin : g_next
         assign tag_prev = tag_ff[j-1];
         assign rem_prev = rem_ff[j-1];
         assign quo_prev = quo_ff[j-1];
         assign den_prev = den_ff[j-1];
      end

      assign den_sh = {{(DW-RW){1'b0}}, den_prev} << K;

      always_comb begin
         rem_in = rem_prev;
         quo_in = quo_prev;
         for (int n = 0; n < 3; n++) begin
            if (rem_prev[n] >= den_sh) begin
               rem_in[n]    = rem_prev[n] - den_sh;
               quo_in[n][K] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff[j].valid <= 1'b0;
         end else if (en) begin
            tag_ff[j] <= tag_prev;
         end
         if (en) begin
            rem_ff[j] <= rem_in;
            quo_ff[j] <= quo_in;
            den_ff[j] <= den_prev;
         end
      end
   end

   assign tag_o = tag_ff[QB-1];
   assign quo_o = quo_ff[QB-1];

endmodule

// ===== sv/axis_angle_to_quaternion.sv =====
// Converts an axis and angle into a unit quaternion. One transfer is taken every clock
// while the result side keeps up. A request passes through two input stages, a 30-stage
// CORDIC for the sine and cosine of the half angle running beside a 32-stage square root
// of the scaled axis length, a multiply stage, a rounding stage, a 16-stage divider (one
// quotient bit per stage) and the output register. A stall on the result side freezes
// the whole pipeline, so req_stall follows rsp_stall whenever a result is waiting. A
// zero-length axis gives the identity quaternion.
module axis_angle_to_quaternion
   import aaq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic en;

   // Stage 1: squares and half-angle range reduction.
   logic                  s1_valid_ff;
   logic [2:0][31:0]      s1_sq_ff;
   logic [2:0][15:0]      s1_axis_ff;
   logic signed [CW-1:0]  s1_z_ff;
   logic                  s1_neg_ff;
   logic signed [34:0]    h_full;
   logic signed [34:0]    h_red;
   logic                  neg_in;
   logic signed [31:0]    sq_x, sq_y, sq_z;

   // Stage 2: squared length.
   logic                  s2_valid_ff;
   logic [31:0]           s2_len_ff;
   logic                  s2_zero_ff;
   logic [2:0][15:0]      s2_axis_ff;
   logic signed [CW-1:0]  s2_z_ff;
   logic                  s2_neg_ff;
   logic [31:0]           len_in;

   side_type              side_ff [SQ_STEPS];
   logic [REMW-1:0]       rem_ff  [SQ_STEPS];
   logic [RW-1:0]         root_ff [SQ_STEPS];
   logic [31:0]           len_ff  [SQ_STEPS];

   logic signed [CW-1:0]  cor_c, cor_s;
   logic signed [CW-1:0]  d1_c_ff, d1_s_ff, d2_c_ff, d2_s_ff;

   // Multiply stage.
   logic                  mul_valid_ff;
   logic                  mul_zero_ff;
   logic signed [15:0]    mul_w_ff;
   logic [2:0]            mul_flip_ff;
   logic [2:0][PW-1:0]    mul_prod_ff;
   logic [RW-1:0]         mul_r_ff;
   logic signed [CW-1:0]  s_abs;
   logic signed [17:0]    w_round;
   logic signed [15:0]    w_in;
   logic [2:0][PW-1:0]    prod_in;
   logic [2:0]            flip_in;

   // Rounding stage, feeding the divider.
   div_tag_type           num_tag_ff;
   logic [2:0][DW-1:0]    num_ff;
   logic [RW-1:0]         num_r_ff;

   div_tag_type           div_tag;
   logic [2:0][QB-1:0]    div_quo;

   logic                  rsp_valid_ff;
   rsp_type               rsp_data_ff;
   rsp_type               rsp_in;

   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   always_comb begin
      h_full = $signed({{2{req_data.angle[15]}}, req_data.angle, 17'b0});
      neg_in = 1'b0;
      h_red  = h_full;
      if (h_full > HALF_PI_Q30) begin
         h_red  = h_full - PI_Q30;
         neg_in = 1'b1;
      end else if (h_full < -HALF_PI_Q30) begin
         h_red  = h_full + PI_Q30;
         neg_in = 1'b1;
      end
      sq_x = 32'(req_data.axis_x) * 32'(req_data.axis_x);
      sq_y = 32'(req_data.axis_y) * 32'(req_data.axis_y);
      sq_z = 32'(req_data.axis_z) * 32'(req_data.axis_z);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_valid;
      end
      if (en) begin
         s1_sq_ff   <= {sq_x, sq_y, sq_z};
         s1_axis_ff <= {req_data.axis_z, req_data.axis_y, req_data.axis_x};
         s1_z_ff    <= h_red[CW-1:0];
         s1_neg_ff  <= neg_in;
      end
   end

   assign len_in = s1_sq_ff[0] + s1_sq_ff[1] + s1_sq_ff[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (en) begin
         s2_len_ff  <= len_in;
         s2_zero_ff <= (len_in == '0);
         s2_axis_ff <= s1_axis_ff;
         s2_z_ff    <= s1_z_ff;
         s2_neg_ff  <= s1_neg_ff;
      end
   end

   aaq_cordic u_cordic (
      .clock (clock),
      .en    (en),
      .z_i   (s2_z_ff),
      .c_o   (cor_c),
      .s_o   (cor_s)
   );

   // Square root of len * 2^32, one root bit per stage; the low 32 bits of the
   // radicand are zero, so only the first sixteen stages bring in new bits.
   for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
      localparam int I = SQ_STEPS - 1 - j;
      side_type        side_prev;
      logic [REMW-1:0] rem_prev, rem_sh, trial, rem_in;
      logic [RW-1:0]   root_prev, root_in;
      logic [31:0]     len_prev;
      logic [1:0]      pair;

      if (j == 0) begin : g_first
         assign side_prev = '{valid: s2_valid_ff, zero: s2_zero_ff, neg: s2_neg_ff,
                              axis: s2_axis_ff};
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign len_prev  = s2_len_ff;
      end else begin : g_next
         assign side_prev = side_ff[j-1];
         assign rem_prev  = rem_ff[j-1];
         assign root_prev = root_ff[j-1];
         assign len_prev  = len_ff[j-1];
      end

      if (I >= 16) begin : g_hi
         assign pair = len_prev[2*(I-16)+1 -: 2];
      end else begin : g_lo
         assign pair = 2'b00;
      end

      always_comb begin
         rem_sh = {rem_prev[REMW-3:0], pair};
         trial  = {2'b00, root_prev, 2'b01};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_prev[RW-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_prev[RW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            side_ff[j].valid <= 1'b0;
         end else if (en) begin
            side_ff[j] <= side_prev;
         end
         if (en) begin
            rem_ff[j]  <= rem_in;
            root_ff[j] <= root_in;
            len_ff[j]  <= len_prev;
         end
      end
   end

   // The CORDIC finishes before the root, so two registers (d1, d2) delay it; the quadrant fold is applied here.
   always_ff @(posedge clock) begin
      if (en) begin
         d1_c_ff <= side_ff[CORDIC_STEPS-1].neg ? -cor_c : cor_c;
         d1_s_ff <= side_ff[CORDIC_STEPS-1].neg ? -cor_s : cor_s;
         d2_c_ff <= d1_c_ff;
         d2_s_ff <= d1_s_ff;
      end
   end

   always_comb begin
      w_round = 18'((d2_c_ff + 34'sd32768) >>> 16);
      if (w_round > 18'sd16384) begin
         w_in = Q14_ONE;
      end else if (w_round < -18'sd16384) begin
         w_in = -Q14_ONE;
      end else begin
         w_in = w_round[15:0];
      end
      s_abs = d2_s_ff[CW-1] ? -d2_s_ff : d2_s_ff;
      for (int n = 0; n < 3; n++) begin
         logic [15:0] a_mag;
         a_mag      = side_ff[SQ_STEPS-1].axis[n][15] ? 16'(-side_ff[SQ_STEPS-1].axis[n])
                                                      : side_ff[SQ_STEPS-1].axis[n];
         prod_in[n] = PW'(a_mag) * PW'(s_abs[31:0]);
         flip_in[n] = side_ff[SQ_STEPS-1].axis[n][15] ^ d2_s_ff[CW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else if (en) begin
         mul_valid_ff <= side_ff[SQ_STEPS-1].valid;
      end
      if (en) begin
         mul_zero_ff <= side_ff[SQ_STEPS-1].zero;
         mul_w_ff    <= w_in;
         mul_flip_ff <= flip_in;
         mul_prod_ff <= prod_in;
         mul_r_ff    <= root_ff[SQ_STEPS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_tag_ff.valid <= 1'b0;
      end else if (en) begin
         num_tag_ff <= '{valid: mul_valid_ff, zero: mul_zero_ff, w: mul_w_ff,
                         flip: mul_flip_ff};
      end
      if (en) begin
         for (int n = 0; n < 3; n++) begin
            num_ff[n] <= {1'b0, mul_prod_ff[n]} + DW'(mul_r_ff[RW-1:1]);
         end
         num_r_ff <= mul_r_ff;
      end
   end

   aaq_div u_div (
      .clock (clock),
      .reset (reset),
      .en    (en),
      .tag_i (num_tag_ff),
      .num_i (num_ff),
      .den_i (num_r_ff),
      .tag_o (div_tag),
      .quo_o (div_quo)
   );

   always_comb begin
      logic [2:0][15:0] comp;
      for (int n = 0; n < 3; n++) begin
         logic [15:0] mag;
         mag     = (div_quo[n] > 16'd16384) ? 16'd16384 : div_quo[n];
         comp[n] = div_tag.flip[n] ? 16'(-mag) : mag;
      end
      if (div_tag.zero) begin
         rsp_in = '{quat_w: Q14_ONE, quat_x: '0, quat_y: '0, quat_z: '0};
      end else begin
         rsp_in = '{quat_w: div_tag.w, quat_x: comp[0], quat_y: comp[1],
                    quat_z: comp[2]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= div_tag.valid;
      end
      if (en) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> s1_valid_ff)
      else $error("accepted request did not enter the first stage");

   a_stall_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("request taken while a result is held");

   a_freeze: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(mul_valid_ff) && $stable(num_tag_ff.valid))
      else $error("pipeline moved while frozen");

endmodule
